FILE: rtl/core/lsb_first_bit_packer_core_macros.svh
// assertion macros used by the packer core rtl
`ifndef LSB_FIRST_BIT_PACKER_CORE_MACROS_SVH
`define LSB_FIRST_BIT_PACKER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define LBP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbp same-cycle check failed");

// next-cycle implication, checked outside reset
`define LBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbp next-cycle check failed");

`endif

FILE: rtl/core/lbp_pkg.sv
package lbp_pkg;

    // field and datapath widths
    localparam int VALUE_WIDTH = 32;
    localparam int COUNT_W     = 6;
    localparam int BYTE_W      = 8;
    localparam int PEND_W      = 7;
    localparam int PCNT_W      = 3;
    localparam int ACC_W       = VALUE_WIDTH + PEND_W;
    localparam int MAX_BYTES   = ACC_W / BYTE_W;
    localparam int NB_W        = $clog2(MAX_BYTES + 1);
    localparam int NSAT_W      = $clog2(VALUE_WIDTH + 1);
    localparam int TOT_W       = $clog2(ACC_W + 1);

    typedef enum logic
    {
        CMD_APPEND = 1'b0,
        CMD_FLUSH  = 1'b1
    } cmd_t;

    // one input beat as held in the input register
    typedef struct packed
    {
        cmd_t                   cmd;
        logic [VALUE_WIDTH-1:0] value;
        logic [COUNT_W-1:0]     bit_count;
    } item_t;

    // bytes produced by one input beat
    typedef struct packed
    {
        logic [MAX_BYTES*BYTE_W-1:0] bytes;
        logic [NB_W-1:0]             nbytes;
    } burst_t;

    // pending partial byte
    typedef struct packed
    {
        logic [PEND_W-1:0] bits;
        logic [PCNT_W-1:0] count;
    } pend_t;

endpackage

FILE: rtl/core/lbp_item_if.sv
interface lbp_item_if;
    import lbp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   cmd;
    logic [VALUE_WIDTH-1:0] value;
    logic [COUNT_W-1:0]     bit_count;

    modport source (output valid, output cmd, output value, output bit_count, input ready);
    modport sink   (input valid, input cmd, input value, input bit_count, output ready);
endinterface

FILE: rtl/core/lbp_byte_if.sv
interface lbp_byte_if;
    import lbp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

FILE: rtl/core/lbp_in_reg.sv
module lbp_in_reg
(
    input  logic           clk,
    input  logic           rst_n,
    lbp_item_if.sink       item,
    input  logic           take,
    output logic           hold_valid,
    output lbp_pkg::item_t hold
);
    import lbp_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t hold_reg;
    item_t hold_next;
    logic  accept;

    // register is free when empty or being drained this cycle
    assign item.ready = !valid_reg || take;
    assign accept     = item.valid && item.ready;

    // next state of the input register
    always_comb
    begin
        valid_next = valid_reg;
        hold_next  = hold_reg;
        if (take)
        begin
            valid_next = 1'b0;
        end
        if (accept)
        begin
            valid_next          = 1'b1;
            hold_next.cmd       = cmd_t'(item.cmd);
            hold_next.value     = item.value;
            hold_next.bit_count = item.bit_count;
        end
    end

    // control flop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload flop
    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

    assign hold_valid = valid_reg;
    assign hold       = hold_reg;
endmodule

FILE: rtl/core/lbp_packer.sv
module lbp_packer
(
    input  logic            clk,
    input  logic            rst_n,
    input  lbp_pkg::item_t  hold,
    input  logic            fire,
    output lbp_pkg::burst_t burst,
    output lbp_pkg::pend_t  pend
);
    import lbp_pkg::*;

    pend_t                  pend_reg;
    pend_t                  pend_next;
    logic [NSAT_W-1:0]      n_sat;
    logic [VALUE_WIDTH-1:0] mask;
    logic [VALUE_WIDTH-1:0] v;
    logic [ACC_W-1:0]       acc;
    logic [ACC_W-1:0]       rest;
    logic [TOT_W-1:0]       total;

    // saturate the count and drop bits above it
    always_comb
    begin
        if (int'(hold.bit_count) > VALUE_WIDTH)
        begin
            n_sat = NSAT_W'(VALUE_WIDTH);
        end
        else
        begin
            n_sat = NSAT_W'(hold.bit_count);
        end
    end

    assign mask  = {VALUE_WIDTH{1'b1}} >> (NSAT_W'(VALUE_WIDTH) - n_sat);
    assign v     = hold.value & mask;

    // join new bits above the pending ones
    assign acc   = ACC_W'(pend_reg.bits) | (ACC_W'(v) << pend_reg.count);
    assign total = TOT_W'(pend_reg.count) + TOT_W'(n_sat);
    assign rest  = acc >> {total[TOT_W-1:3], 3'b000};

    // bytes out and next pending state
    always_comb
    begin
        unique case (hold.cmd)
            CMD_FLUSH:
            begin
                burst.bytes  = (MAX_BYTES*BYTE_W)'(pend_reg.bits);
                burst.nbytes = (pend_reg.count != '0) ? NB_W'(1) : '0;
                pend_next    = '0;
            end
            CMD_APPEND:
            begin
                burst.bytes     = acc[MAX_BYTES*BYTE_W-1:0];
                burst.nbytes    = NB_W'(total >> 3);
                pend_next.bits  = rest[PEND_W-1:0];
                pend_next.count = total[PCNT_W-1:0];
            end
            default:
            begin
                burst     = '0;
                pend_next = pend_reg;
            end
        endcase
    end

    // pending state flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if (fire)
        begin
            pend_reg <= pend_next;
        end
    end

    assign pend = pend_reg;
endmodule

FILE: rtl/core/lbp_burst.sv
module lbp_burst
(
    input  logic            clk,
    input  logic            rst_n,
    input  lbp_pkg::burst_t burst_in,
    input  logic            load_req,
    output logic            free,
    lbp_byte_if.source      stream
);
    import lbp_pkg::*;

    logic [MAX_BYTES*BYTE_W-1:0] bytes_reg;
    logic [MAX_BYTES*BYTE_W-1:0] bytes_next;
    logic [NB_W-1:0]             rem_reg;
    logic [NB_W-1:0]             rem_next;
    logic                        pop;
    logic                        load;

    // free when empty or the last byte leaves this cycle
    assign pop  = stream.valid && stream.ready;
    assign free = (rem_reg == '0) || ((rem_reg == NB_W'(1)) && stream.ready);
    assign load = load_req && free;

    // shift out one byte per beat, reload on a new burst
    always_comb
    begin
        bytes_next = bytes_reg;
        rem_next   = rem_reg;
        if (pop)
        begin
            bytes_next = bytes_reg >> BYTE_W;
            rem_next   = rem_reg - NB_W'(1);
        end
        if (load)
        begin
            bytes_next = burst_in.bytes;
            rem_next   = burst_in.nbytes;
        end
    end

    // byte count flop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
        end
    end

    // byte data flop
    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

    assign stream.valid    = rem_reg != '0;
    assign stream.out_byte = bytes_reg[BYTE_W-1:0];
    assign stream.last     = rem_reg == NB_W'(1);
endmodule

FILE: rtl/core/lsb_first_bit_packer_core.sv
// LSB-first variable-length bit packer.
// item channel: cmd selects append (value, bit_count of 0..32 low bits) or
// flush (emit the partial byte padded with zeros, clear pending bits).
// stream channel: packed bytes, earliest bit in bit 0; last marks the final
// byte caused by one item. Items that complete no byte give no beat.
// An item is registered in the input register on accept, packed as soon
// as the byte register is free, and its bytes are offered from the byte
// register. Throughput: one item per cycle when it yields at most one byte
// and the receiver is ready; an item yielding more bytes holds the byte
// register while they drain at one byte per beat, which paces multi-byte
// appends. The next item is taken while bytes still drain.
// Reset clears pending bits, the input register valid flag and the byte
// count of the byte register; no beat is offered until an item arrives.
// When the receiver stalls the current byte holds, the next burst waits
// in the input register, and item.ready drops once that register is full.
module lsb_first_bit_packer_core
(
    input  logic       clk,
    input  logic       rst_n,
    lbp_item_if.sink   item,
    lbp_byte_if.source stream
);
    import lbp_pkg::*;

    `include "lsb_first_bit_packer_core_macros.svh"

    logic   hold_valid;
    item_t  hold;
    logic   free;
    logic   fire;
    burst_t burst;
    pend_t  pend;

    assign fire = hold_valid && free;

    // input register
    lbp_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .take       (fire),
        .hold_valid (hold_valid),
        .hold       (hold)
    );

    // bit packing and pending state
    lbp_packer u_packer
    (
        .clk   (clk),
        .rst_n (rst_n),
        .hold  (hold),
        .fire  (fire),
        .burst (burst),
        .pend  (pend)
    );

    // byte result register
    lbp_burst u_burst
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .burst_in (burst),
        .load_req (hold_valid),
        .free     (free),
        .stream   (stream)
    );

    // checks
    `LBP_ASSERT_IMPL(a_pend_clean, clk, rst_n, 1'b1, (pend.bits >> pend.count) == '0)
    `LBP_ASSERT_NEXT(a_burst_cont, clk, rst_n, stream.valid && stream.ready && !stream.last, stream.valid)
    `LBP_ASSERT_NEXT(a_flush_clears, clk, rst_n, fire && (hold.cmd == CMD_FLUSH), pend.count == '0)
endmodule
